>>> src/dmq_pkg.sv
// ----------------------------------------------------------------------------
// Deadline-ordered message queue: shared types
// Payload structs, command and error codes, and the control and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package dmq_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_GET    = 2'd2,
      CMD_MARK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ERR_OK     = 2'd0,
      ERR_FULL   = 2'd1,
      ERR_ABSENT = 2'd2
   } err_type;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  handle;
      logic [31:0] deadline;
      logic        queued;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [7:0]  result_handle;
      err_type     error_code;
      logic [4:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  handle;
      logic [31:0] deadline;
      logic        queued;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_INS_SCAN,
      ST_INS_HEAD,
      ST_REM_SEEK,
      ST_REM_SHIFT,
      ST_MARK_SEEK,
      ST_GET_SCAN,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_FIRST,
      RD_NEXT,
      RD_PREV,
      RD_LAST
   } rd_op_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_NEW_ZERO,
      WR_NEW_NEXT,
      WR_FWD,
      WR_BACK,
      WR_MARK
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [2:0] {
      RES_HOLD,
      RES_CLEAR,
      RES_FULL,
      RES_ABSENT,
      RES_FOUND
   } res_op_type;

   typedef struct packed {
      logic       latch_req;
      rd_op_type  rd_op;
      wr_op_type  wr_op;
      cnt_op_type cnt_op;
      res_op_type res_op;
      logic       publish;
   } ctl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    count_zero;
      logic    count_full;
      logic    scan_empty;
      logic    idx_zero;
      logic    idx_last;
      logic    hit_handle;
      logic    hit_queued;
      logic    dl_less;
      logic    out_free;
   } sts_type;

endpackage

>>> src/dmq_ctrl.sv
// ----------------------------------------------------------------------------
// Deadline-ordered message queue: controller
// Sequences one command at a time over the entry memory of the datapath.
// ----------------------------------------------------------------------------
module dmq_ctrl
   import dmq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output ctl_type ctl,
   input  sts_type sts
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            case (sts.cmd)
               CMD_INSERT: begin
                  if (sts.count_full || sts.count_zero) state_in = ST_FINISH;
                  else state_in = ST_INS_SCAN;
               end
               CMD_REMOVE: begin
                  if (sts.count_zero) state_in = ST_FINISH;
                  else state_in = ST_REM_SEEK;
               end
               CMD_MARK: begin
                  if (sts.count_zero) state_in = ST_FINISH;
                  else state_in = ST_MARK_SEEK;
               end
               CMD_GET: begin
                  if (sts.scan_empty) state_in = ST_FINISH;
                  else state_in = ST_GET_SCAN;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_INS_SCAN: begin
            if (!sts.dl_less) state_in = ST_FINISH;
            else if (sts.idx_zero) state_in = ST_INS_HEAD;
         end
         ST_INS_HEAD: state_in = ST_FINISH;
         ST_REM_SEEK: begin
            if (sts.idx_last) state_in = ST_FINISH;
            else if (sts.hit_handle) state_in = ST_REM_SHIFT;
         end
         ST_REM_SHIFT: begin
            if (sts.idx_last) state_in = ST_FINISH;
         end
         ST_MARK_SEEK: begin
            if (sts.hit_handle || sts.idx_last) state_in = ST_FINISH;
         end
         ST_GET_SCAN: begin
            if (sts.hit_queued || sts.idx_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready     = 1'b0;
      ctl.latch_req = 1'b0;
      ctl.rd_op     = RD_NONE;
      ctl.wr_op     = WR_NONE;
      ctl.cnt_op    = CNT_HOLD;
      ctl.res_op    = RES_HOLD;
      ctl.publish   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch_req = 1'b1;
               ctl.res_op    = RES_CLEAR;
            end
         end
         ST_DISPATCH: begin
            case (sts.cmd)
               CMD_INSERT: begin
                  if (sts.count_full) begin
                     ctl.res_op = RES_FULL;
                  end else if (sts.count_zero) begin
                     ctl.wr_op  = WR_NEW_ZERO;
                     ctl.cnt_op = CNT_INC;
                  end else begin
                     ctl.rd_op = RD_LAST;
                  end
               end
               CMD_REMOVE, CMD_MARK: begin
                  if (sts.count_zero) ctl.res_op = RES_ABSENT;
                  else ctl.rd_op = RD_FIRST;
               end
               CMD_GET: begin
                  if (!sts.scan_empty) ctl.rd_op = RD_FIRST;
               end
               default: ctl.res_op = RES_HOLD;
            endcase
         end
         ST_INS_SCAN: begin
            if (sts.dl_less) begin
               ctl.wr_op = WR_FWD;
               if (!sts.idx_zero) ctl.rd_op = RD_PREV;
            end else begin
               ctl.wr_op  = WR_NEW_NEXT;
               ctl.cnt_op = CNT_INC;
            end
         end
         ST_INS_HEAD: begin
            ctl.wr_op  = WR_NEW_ZERO;
            ctl.cnt_op = CNT_INC;
         end
         ST_REM_SEEK: begin
            if (sts.hit_handle && sts.idx_last) ctl.cnt_op = CNT_DEC;
            else if (sts.idx_last) ctl.res_op = RES_ABSENT;
            else ctl.rd_op = RD_NEXT;
         end
         ST_REM_SHIFT: begin
            ctl.wr_op = WR_BACK;
            if (sts.idx_last) ctl.cnt_op = CNT_DEC;
            else ctl.rd_op = RD_NEXT;
         end
         ST_MARK_SEEK: begin
            if (sts.hit_handle) ctl.wr_op = WR_MARK;
            else if (sts.idx_last) ctl.res_op = RES_ABSENT;
            else ctl.rd_op = RD_NEXT;
         end
         ST_GET_SCAN: begin
            if (sts.hit_queued) ctl.res_op = RES_FOUND;
            else if (!sts.idx_last) ctl.rd_op = RD_NEXT;
         end
         ST_FINISH: begin
            ctl.publish = sts.out_free;
         end
         default: req_ready = 1'b0;
      endcase
   end

endmodule

>>> src/dmq_datapath.sv
// ----------------------------------------------------------------------------
// Deadline-ordered message queue: datapath
// Entry memory with one write and one registered read port, the walking
// index, the entry count and the result and output registers.
// ----------------------------------------------------------------------------
module dmq_datapath
   import dmq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int SCAN_LIMIT  = 3
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  ctl_type ctl,
   output sts_type sts
);

   localparam int IW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW       = $clog2(QUEUE_DEPTH + 1);
   localparam int SCAN_CAP = (SCAN_LIMIT < QUEUE_DEPTH) ? SCAN_LIMIT : QUEUE_DEPTH;

   entry_type       mem [QUEUE_DEPTH];
   req_type         req_ff;
   entry_type       rd_data_ff;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            res_found_ff, res_found_in;
   logic [7:0]      res_handle_ff, res_handle_in;
   err_type         res_err_ff, res_err_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            rd_en;
   logic [IW-1:0]   rd_addr;
   logic            wr_en;
   logic [IW-1:0]   wr_addr;
   entry_type       wr_data;
   entry_type       new_entry;
   logic [CW-1:0]   scan_lim;
   logic [CW-1:0]   limit;
   logic [CW-1:0]   idx_plus;

   assign new_entry = '{handle: req_ff.handle, deadline: req_ff.deadline,
                        queued: req_ff.queued};

   // Read address: the index register always names the entry in rd_data_ff.
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = idx_ff;
      case (ctl.rd_op)
         RD_NONE:  rd_en = 1'b0;
         RD_FIRST: rd_addr = '0;
         RD_NEXT:  rd_addr = idx_ff + 1'b1;
         RD_PREV:  rd_addr = idx_ff - 1'b1;
         RD_LAST:  rd_addr = IW'(count_ff - 1'b1);
         default:  rd_en = 1'b0;
      endcase
      idx_in = rd_en ? rd_addr : idx_ff;
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = idx_ff;
      wr_data = new_entry;
      case (ctl.wr_op)
         WR_NONE:     wr_en = 1'b0;
         WR_NEW_ZERO: wr_addr = '0;
         WR_NEW_NEXT: wr_addr = idx_ff + 1'b1;
         WR_FWD: begin
            wr_addr = idx_ff + 1'b1;
            wr_data = rd_data_ff;
         end
         WR_BACK: begin
            wr_addr = idx_ff - 1'b1;
            wr_data = rd_data_ff;
         end
         WR_MARK: begin
            wr_data        = rd_data_ff;
            wr_data.queued = req_ff.queued;
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      case (ctl.cnt_op)
         CNT_INC: count_in = count_ff + 1'b1;
         CNT_DEC: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_comb begin
      res_found_in  = res_found_ff;
      res_handle_in = res_handle_ff;
      res_err_in    = res_err_ff;
      case (ctl.res_op)
         RES_CLEAR: begin
            res_found_in  = 1'b0;
            res_handle_in = '0;
            res_err_in    = ERR_OK;
         end
         RES_FULL:   res_err_in = ERR_FULL;
         RES_ABSENT: res_err_in = ERR_ABSENT;
         RES_FOUND: begin
            res_found_in  = 1'b1;
            res_handle_in = rd_data_ff.handle;
         end
         default: res_found_in = res_found_ff;
      endcase
   end

   // Output register: freed when the receiver takes the transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (ctl.publish) begin
         rsp_valid_in         = 1'b1;
         rsp_in.found         = res_found_ff;
         rsp_in.result_handle = res_handle_ff;
         rsp_in.error_code    = res_err_ff;
         rsp_in.occupancy     = 5'(count_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch_req) req_ff <= req_data;
      res_found_ff  <= res_found_in;
      res_handle_ff <= res_handle_in;
      res_err_ff    <= res_err_in;
      rsp_ff        <= rsp_in;
   end

   // Get only looks at the leading entries; the other commands may walk them all.
   assign scan_lim = (count_ff < CW'(SCAN_CAP)) ? count_ff : CW'(SCAN_CAP);
   assign limit    = (req_ff.command == CMD_GET) ? scan_lim : count_ff;
   assign idx_plus = CW'(idx_ff) + CW'(1);

   assign sts.cmd        = req_ff.command;
   assign sts.count_zero = (count_ff == '0);
   assign sts.count_full = (count_ff == CW'(QUEUE_DEPTH));
   assign sts.scan_empty = (scan_lim == '0);
   assign sts.idx_zero   = (idx_ff == '0);
   assign sts.idx_last   = (idx_plus >= limit);
   assign sts.hit_handle = (rd_data_ff.handle == req_ff.handle);
   assign sts.hit_queued = rd_data_ff.queued;
   assign sts.dl_less    = (req_ff.deadline < rd_data_ff.deadline);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> src/deadline_ordered_message_queue.sv
// ----------------------------------------------------------------------------
// Deadline-ordered message queue
// Earliest-deadline-first queue of message handles with insert, remove,
// get-first-queued and set-queued-mark commands.
// ----------------------------------------------------------------------------
// Usage: one command is presented on the req_ channel (valid/ready) and
// produces exactly one transfer on the rsp_ channel. Entries are kept in
// ascending deadline order; a new entry goes behind entries of equal
// deadline. Commands are handled one at a time; req_ready is high only
// while the controller is idle.
// With N entries held, a rejected insert or any command on an empty queue
// finishes without walking the entries; insert moves back each entry that
// ends up behind the new one; remove always walks all N entries; set mark
// walks up to the handle (all N when the handle is absent); get walks the
// entries up to the first queued one, at most SCAN_LIMIT. The pace is set by
// the single read and single write port of the entry memory, which the
// controller walks one entry per cycle.
// The controller is idle again once the response is loaded, even if the
// receiver has not yet taken it; a stalled receiver holds the response in
// the output register and only blocks the following command from finishing.
// Reset empties the queue at once; entry memory contents are not cleared.
// ----------------------------------------------------------------------------
module deadline_ordered_message_queue
   import dmq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int SCAN_LIMIT  = 3
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Command bundle from the controller and status bundle back from the
   // datapath; these are the only links between the two.
   ctl_type ctl;
   sts_type sts;

   dmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   dmq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .SCAN_LIMIT  (SCAN_LIMIT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .sts       (sts)
   );

`ifndef SYNTH
   // A full-queue rejection must report the queue as full.
   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.error_code == ERR_FULL |->
         rsp_data.occupancy == 5'(QUEUE_DEPTH))
      else $error("full error reported with queue not full");

   // A found entry never comes with an error.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.error_code == ERR_OK)
      else $error("found entry reported together with an error");

   // When nothing was found the handle field must read zero.
   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.result_handle == 8'd0)
      else $error("handle returned without a found entry");

   // The queue is never modified while the controller waits for a request.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> ctl.wr_op == WR_NONE && ctl.cnt_op == CNT_HOLD)
      else $error("entry memory or count changed while idle");
`endif

endmodule

>>> tb/sv/tb_deadline_ordered_message_queue.sv
// ----------------------------------------------------------------------------
// Testbench for the deadline-ordered message queue
// Drives insert, remove, get and set-mark commands through the request
// channel, predicts every response with a behavioural copy of the sorted
// queue, and checks each response transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_deadline_ordered_message_queue;
   import dmq_pkg::*;

   localparam int QUEUE_DEPTH    = 16;
   localparam int SCAN_LIMIT     = 3;
   localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
   localparam int HOLD_OFF       = 400;   // long receiver stall for the receiver-hold test
   localparam int DRAIN_CYCLES   = 40;    // settling time after the last response

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // Behavioural copy of the queue contents, kept in deadline order.
   entry_type model_slot [QUEUE_DEPTH];
   int        model_count;

   // Responses predicted but not yet seen on the response channel.
   rsp_type   pending_rsp [$];
   int        mismatch_count;
   int        quiet_cycles;

   // Idling switches and the one-off receiver hold request.
   bit        send_idling;
   bit        recv_idling;
   int        hold_off_cycles;

   deadline_ordered_message_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .SCAN_LIMIT  (SCAN_LIMIT)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Position of the first entry holding the handle, or model_count if none.
   function automatic int locate_handle(input logic [7:0] handle);
      for (int i = 0; i < model_count; i++) begin
         if (model_slot[i].handle == handle) begin
            return i;
         end
      end
      return model_count;
   endfunction

   // Applies one command to the queue copy and returns the response it earns.
   function automatic rsp_type apply_command(input req_type r);
      rsp_type rsp;
      int      pos;
      int      scan_end;
      rsp            = '0;
      rsp.error_code = ERR_OK;
      case (r.command)
         CMD_INSERT: begin
            if (model_count >= QUEUE_DEPTH) begin
               rsp.error_code = ERR_FULL;
            end else begin
               // A new entry goes behind every entry with an equal or earlier
               // deadline, so equal deadlines keep their arrival order.
               pos = 0;
               while (pos < model_count && r.deadline >= model_slot[pos].deadline) begin
                  pos++;
               end
               for (int i = model_count; i > pos; i--) begin
                  model_slot[i] = model_slot[i - 1];
               end
               model_slot[pos] = '{handle: r.handle, deadline: r.deadline, queued: r.queued};
               model_count++;
            end
         end
         CMD_REMOVE: begin
            pos = locate_handle(r.handle);
            if (pos >= model_count) begin
               rsp.error_code = ERR_ABSENT;
            end else begin
               for (int i = pos; i + 1 < model_count; i++) begin
                  model_slot[i] = model_slot[i + 1];
               end
               model_count--;
            end
         end
         CMD_GET: begin
            // Only the leading entries are looked at; a queued entry further
            // back is not reported.
            scan_end = (model_count < SCAN_LIMIT) ? model_count : SCAN_LIMIT;
            for (int i = 0; i < scan_end; i++) begin
               if (model_slot[i].queued) begin
                  rsp.found         = 1'b1;
                  rsp.result_handle = model_slot[i].handle;
                  break;
               end
            end
         end
         default: begin
            pos = locate_handle(r.handle);
            if (pos >= model_count) begin
               rsp.error_code = ERR_ABSENT;
            end else begin
               model_slot[pos].queued = r.queued;
            end
         end
      endcase
      rsp.occupancy = 5'(model_count);
      return rsp;
   endfunction

   // Every accepted request is predicted at the edge of its transfer. Inputs
   // are driven with nonblocking assignments, so the values read here are
   // those that were present at the edge.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         pending_rsp.push_back(apply_command(req_data));
      end
   end

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected response transfer: found=%0b handle=%0d err=%0d occ=%0d",
                        rsp_data.found, rsp_data.result_handle, rsp_data.error_code,
                        rsp_data.occupancy);
            end
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.found !== want.found ||
                rsp_data.result_handle !== want.result_handle ||
                rsp_data.error_code !== want.error_code ||
                rsp_data.occupancy !== want.occupancy) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("response mismatch at %0t:", $realtime,
                           " expected found=%0b handle=%0d err=%0d occ=%0d,",
                           want.found, want.result_handle, want.error_code,
                           want.occupancy,
                           " got found=%0b handle=%0d err=%0d occ=%0d",
                           rsp_data.found, rsp_data.result_handle,
                           rsp_data.error_code, rsp_data.occupancy);
               end
            end
         end
      end
   end

   // The watchdog ends a run in which no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Idle length: mostly none, often short, now and then long.
   function automatic int idle_length(input bit enabled);
      if (!enabled || $urandom_range(0, 2) != 0) begin
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic req_type make_req(input cmd_type cmd, input logic [7:0] handle,
                                        input logic [31:0] deadline, input logic queued);
      req_type r;
      r.command  = cmd;
      r.handle   = handle;
      r.deadline = deadline;
      r.queued   = queued;
      return r;
   endfunction

   // A third of the deadlines come from a narrow range so that ties are common;
   // the extremes and the full range make up the rest.
   function automatic logic [31:0] pick_deadline();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return 32'($urandom_range(0, 15));
         default: return $urandom();
      endcase
   endfunction

   // Either a handle that is currently held, or any handle at all.
   function automatic logic [7:0] pick_handle(input bit prefer_held);
      if (prefer_held && model_count > 0) begin
         return model_slot[$urandom_range(0, model_count - 1)].handle;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Offers one command and returns at the edge of its transfer. The valid
   // stays high into the next command unless an idle gap is drawn.
   task automatic send_command(input req_type r);
      int gap;
      gap = idle_length(send_idling);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering and waits until every predicted response has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // The receiver stalls at random, and once holds off for a long stretch.
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            stall           = hold_off_cycles;
            hold_off_cycles = 0;
         end else begin
            stall = idle_length(recv_idling);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Empty-queue commands, the extremes of handle and deadline, equal
   // deadlines, a duplicated handle, the scan limit and absent handles.
   task automatic test_directed_basics();
      send_command(make_req(CMD_GET,    8'h00, 32'h0000_0000, 1'b1));
      send_command(make_req(CMD_REMOVE, 8'h12, 32'hFFFF_FFFF, 1'b0));
      send_command(make_req(CMD_MARK,   8'h12, 32'h0000_0000, 1'b1));
      send_command(make_req(CMD_INSERT, 8'h00, 32'hFFFF_FFFF, 1'b0));
      send_command(make_req(CMD_INSERT, 8'hFF, 32'h0000_0000, 1'b0));
      // Same deadline as the head: must land behind it.
      send_command(make_req(CMD_INSERT, 8'h5A, 32'h0000_0000, 1'b1));
      // The same handle a second time is accepted as a separate entry.
      send_command(make_req(CMD_INSERT, 8'h5A, 32'h8000_0000, 1'b1));
      send_command(make_req(CMD_GET,    8'hA5, 32'hFFFF_FFFF, 1'b0));
      // Marking a duplicated handle touches the entry nearest the head only.
      send_command(make_req(CMD_MARK,   8'h5A, 32'h0000_0000, 1'b0));
      send_command(make_req(CMD_GET,    8'h00, 32'h0000_0000, 1'b0));
      send_command(make_req(CMD_MARK,   8'h5A, 32'h0000_0000, 1'b0));
      // This pushes the one queued entry out of the scanned span.
      send_command(make_req(CMD_INSERT, 8'hC3, 32'h0000_0000, 1'b0));
      send_command(make_req(CMD_GET,    8'h00, 32'h0000_0000, 1'b1));
      send_command(make_req(CMD_MARK,   8'h00, 32'h1234_5678, 1'b1));
      send_command(make_req(CMD_GET,    8'hFF, 32'h0000_0000, 1'b0));
      send_command(make_req(CMD_MARK,   8'hFF, 32'h0000_0000, 1'b1));
      send_command(make_req(CMD_GET,    8'h00, 32'h0000_0000, 1'b0));
      send_command(make_req(CMD_REMOVE, 8'h5A, 32'h0000_0000, 1'b1));
      send_command(make_req(CMD_REMOVE, 8'h77, 32'h0000_0000, 1'b0));
      send_command(make_req(CMD_REMOVE, 8'hFF, 32'h0000_0000, 1'b0));
      send_command(make_req(CMD_REMOVE, 8'hC3, 32'h0000_0000, 1'b0));
      send_command(make_req(CMD_REMOVE, 8'h5A, 32'h0000_0000, 1'b0));
      send_command(make_req(CMD_REMOVE, 8'h00, 32'h0000_0000, 1'b0));
      send_command(make_req(CMD_GET,    8'h00, 32'h0000_0000, 1'b1));
      wait_drained();
   endtask

   // Fills the queue, offers an insert to the full queue, then empties it.
   task automatic test_full_queue();
      logic [7:0] held [QUEUE_DEPTH];
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         held[i] = pick_handle($urandom_range(0, 3) == 0);
         send_command(make_req(CMD_INSERT, held[i], pick_deadline(), 1'($urandom_range(0, 1))));
      end
      send_command(make_req(CMD_INSERT, 8'hEE, 32'h0000_0000, 1'b1));
      send_command(make_req(CMD_GET, 8'h00, 32'h0000_0000, 1'b0));
      send_command(make_req(CMD_MARK, held[QUEUE_DEPTH - 1], 32'h0000_0000, 1'b1));
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         send_command(make_req(CMD_REMOVE, held[i], $urandom(), 1'($urandom_range(0, 1))));
      end
      wait_drained();
   endtask

   // The receiver holds off while commands keep coming, so the response
   // register stays occupied and the block must stop taking requests.
   task automatic test_receiver_hold();
      send_idling     = 1'b0;
      hold_off_cycles = HOLD_OFF;
      for (int i = 0; i < 24; i++) begin
         send_command(make_req(cmd_type'((i % 3 == 2) ? CMD_GET : CMD_INSERT),
                               pick_handle(1'b0), pick_deadline(),
                               1'($urandom_range(0, 1))));
      end
      wait_drained();
   endtask

   // Random commands, mostly well formed: removes and marks usually name a
   // held handle, inserts sometimes reuse one. The insert share steers the
   // occupancy towards full or towards empty.
   task automatic test_random_traffic(input int n_items, input int insert_pct);
      req_type r;
      int      roll;
      for (int k = 0; k < n_items; k++) begin
         roll       = $urandom_range(0, 99);
         r.queued   = 1'($urandom_range(0, 1));
         r.deadline = pick_deadline();
         if (roll < insert_pct) begin
            r.command = CMD_INSERT;
            r.handle  = pick_handle($urandom_range(0, 3) == 0);
         end else if (roll < insert_pct + 25) begin
            r.command = CMD_GET;
            r.handle  = pick_handle(1'b0);
         end else begin
            r.command = cmd_type'(($urandom_range(0, 1) != 0) ? CMD_REMOVE : CMD_MARK);
            r.handle  = pick_handle($urandom_range(0, 4) != 0);
         end
         send_command(r);
      end
      wait_drained();
   endtask

   // -------------------------------------------------------------------------
   // Sequence of tests
   // -------------------------------------------------------------------------

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_data        <= '0;
      model_count     = 0;
      mismatch_count  = 0;
      quiet_cycles    = 0;
      hold_off_cycles = 0;
      send_idling     = 1'b0;
      recv_idling     = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_basics();

      send_idling = 1'b1;
      recv_idling = 1'b1;
      test_full_queue();

      recv_idling = 1'b0;
      test_receiver_hold();

      // Filling, then draining with no idling at all, then a balanced mix.
      send_idling = 1'b1;
      recv_idling = 1'b1;
      test_random_traffic(400, 55);
      send_idling = 1'b0;
      recv_idling = 1'b0;
      test_random_traffic(400, 20);
      send_idling = 1'b1;
      recv_idling = 1'b1;
      test_random_traffic(400, 38);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/dmq_pkg.sv
src/dmq_ctrl.sv
src/dmq_datapath.sv
src/deadline_ordered_message_queue.sv
tb/sv/tb_deadline_ordered_message_queue.sv
